// ===== rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg: shared types and codes for the cube-map texel sampler
// Action, status and face codes, field widths and the side-band record
// that travels with each transaction through the divider pipeline.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int CHAN_W  = 16;
   localparam int TEXEL_W = 4 * CHAN_W;
   localparam int DIR_W   = 16;
   localparam int LEVEL_W = 3;
   localparam int FACE_W  = 3;
   localparam int TEX_W   = 6;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 2;
   localparam int SIZE_W  = 3;
   // wide enough for any level shift of the supported chain depths
   localparam int SHIFT_W = 4;

   localparam logic [ACT_W-1:0] ACT_WRITE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_NEAREST  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_BILINEAR = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
   localparam logic [STAT_W-1:0] ST_LEVEL = 2'd2;

   localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
   localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
   localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd6;

   typedef struct packed {
      logic                 is_write;
      logic                 is_bilin;
      logic [LEVEL_W-1:0]   level;
      logic [FACE_W-1:0]    face;
      logic [STAT_W-1:0]    status;
      logic [TEX_W-1:0]     tex_x;
      logic [TEX_W-1:0]     tex_y;
      logic [TEXEL_W-1:0]   texel;
   } side_type;

   // first bank entry of a level; every bank holds a quarter of each face,
   // at least one texel per face
   function automatic int lvl_base(input int lvl, input int max_log2);
      int acc;
      int h;
      acc = 0;
      for (int k = 0; k < 16; k++) begin
         if (k < lvl) begin
            h = max_log2 - k - 1;
            if (h < 0) h = 0;
            acc = acc + (6 << (2 * h));
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/cts_div.sv =====
// ----------------------------------------------------------------------------
// cts_div: pipelined restoring divider, two numerators over one divisor
// One quotient bit per stage, most significant first; the first stage
// gives the integer bit. Carries a side-band word aligned with the data.
// ----------------------------------------------------------------------------
module cts_div #(
   parameter int NUM_W  = 17,
   parameter int QUO_W  = 15,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  num_u,
   input  logic [NUM_W-1:0]  num_v,
   input  logic [NUM_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [QUO_W-1:0]  quo_u,
   output logic [QUO_W-1:0]  quo_v,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = NUM_W + 1;

   logic [REM_W-1:0]  ru_ff   [QUO_W];
   logic [REM_W-1:0]  rv_ff   [QUO_W];
   logic [QUO_W-1:0]  qu_ff   [QUO_W];
   logic [QUO_W-1:0]  qv_ff   [QUO_W];
   logic [NUM_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [QUO_W-1:0]  vld_ff;

   logic [REM_W-1:0]  tu      [QUO_W];
   logic [REM_W-1:0]  tv      [QUO_W];
   logic [REM_W-1:0]  dd      [QUO_W];
   logic [QUO_W-1:0]  pu      [QUO_W];
   logic [QUO_W-1:0]  pv      [QUO_W];
   logic [SIDE_W-1:0] ps      [QUO_W];
   logic [QUO_W-1:0]  pvld;
   logic [QUO_W-1:0]  geu;
   logic [QUO_W-1:0]  gev;

   // trial remainders: first stage takes the numerator, later ones double
   always_comb begin
      tu[0]   = {1'b0, num_u};
      tv[0]   = {1'b0, num_v};
      dd[0]   = {1'b0, den};
      pu[0]   = '0;
      pv[0]   = '0;
      ps[0]   = in_side;
      pvld[0] = in_vld;
      for (int i = 1; i < QUO_W; i++) begin
         tu[i]   = {ru_ff[i-1][REM_W-2:0], 1'b0};
         tv[i]   = {rv_ff[i-1][REM_W-2:0], 1'b0};
         dd[i]   = {1'b0, den_ff[i-1]};
         pu[i]   = qu_ff[i-1];
         pv[i]   = qv_ff[i-1];
         ps[i]   = side_ff[i-1];
         pvld[i] = vld_ff[i-1];
      end
      for (int i = 0; i < QUO_W; i++) begin
         geu[i] = (tu[i] >= dd[i]);
         gev[i] = (tv[i] >= dd[i]);
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= pvld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QUO_W; i++) begin
            ru_ff[i]   <= geu[i] ? tu[i] - dd[i] : tu[i];
            rv_ff[i]   <= gev[i] ? tv[i] - dd[i] : tv[i];
            qu_ff[i]   <= {pu[i][QUO_W-2:0], geu[i]};
            qv_ff[i]   <= {pv[i][QUO_W-2:0], gev[i]};
            den_ff[i]  <= dd[i][NUM_W-1:0];
            side_ff[i] <= ps[i];
         end
      end
   end

   assign out_vld  = vld_ff[QUO_W-1];
   assign quo_u    = qu_ff[QUO_W-1];
   assign quo_v    = qv_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];

endmodule

// ===== rtl/cts_bank.sv =====
// ----------------------------------------------------------------------------
// cts_bank: one parity bank of the texel store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cts_bank #(
   parameter int ADDR_W = 13,
   parameter int DEPTH  = 8196,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // store a texel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read, hold while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cts_blend.sv =====
// ----------------------------------------------------------------------------
// cts_blend: two-stage bilinear blend of four RGBA texels
// Stage one blends along x per row, stage two along y; the output rounds
// and saturates the registered sum.
// ----------------------------------------------------------------------------
module cts_blend
   import cts_pkg::*;
#(
   parameter int FRAC = 8
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [3:0][TEXEL_W-1:0]       tex,
   input  logic [FRAC:0]                 wx,
   input  logic [FRAC:0]                 wy,
   output logic [3:0][CHAN_W-1:0]        color
);

   localparam int H_W = CHAN_W + FRAC + 1;
   localparam int S_W = CHAN_W + 2 * FRAC + 2;
   localparam logic [FRAC:0]  ONE  = (FRAC + 1)'(1) << FRAC;
   localparam logic [S_W-1:0] HALF = S_W'(1) << (2 * FRAC - 1);
   localparam logic [S_W-1:0] SAT  = S_W'({CHAN_W{1'b1}});

   logic [3:0][H_W-1:0] h0_ff;
   logic [3:0][H_W-1:0] h1_ff;
   logic [FRAC:0]       wy_ff;
   logic [3:0][S_W-1:0] sum_ff;
   logic [3:0][S_W-1:0] rnd;
   logic [FRAC:0]       wxn;
   logic [FRAC:0]       wyn;

   assign wxn = ONE - wx;
   assign wyn = ONE - wy_ff;

   // blend along x
   always_ff @(posedge clock) begin
      if (en) begin
         wy_ff <= wy;
         for (int c = 0; c < 4; c++) begin
            h0_ff[c] <= H_W'(tex[0][c*CHAN_W +: CHAN_W] * wxn)
                      + H_W'(tex[1][c*CHAN_W +: CHAN_W] * wx);
            h1_ff[c] <= H_W'(tex[2][c*CHAN_W +: CHAN_W] * wxn)
                      + H_W'(tex[3][c*CHAN_W +: CHAN_W] * wx);
         end
      end
   end

   // blend along y
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= S_W'(h0_ff[c] * wyn) + S_W'(h1_ff[c] * wy_ff);
         end
      end
   end

   // round and saturate
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         rnd[c] = (sum_ff[c] + HALF) >> (2 * FRAC);
         color[c] = (rnd[c] > SAT) ? {CHAN_W{1'b1}} : rnd[c][CHAN_W-1:0];
      end
   end

endmodule

// ===== rtl/cubemap_texel_sampler_core.sv =====
// ----------------------------------------------------------------------------
// cubemap_texel_sampler_core: cube-map mip chain store with texel sampler
// Picks the major-axis face of a direction, forms face coordinates by a
// pipelined divider, reads four parity banks and blends the result.
//
//  channel | ports                         | direction | carries
//  --------+-------------------------------+-----------+---------------------
//  request | req_tvalid/tready/tdata/tuser | in        | write or sample
//  result  | rsp_tvalid/tready/tdata/tuser | out       | color, face, status
//  csr     | csr_valid/ready/data          | in        | size_log2
//
//  One transaction per cycle while the result channel is not stalled. A result
//  passes the input register, the one-bit-per-stage divider, the bank read,
//  the blend stages and the output register.
//  Texels sit in four banks split by row and column parity, so one bilinear
//  footprint reads once from each bank in a single cycle.
//  A stalled result holds the output register; the pipeline keeps moving
//  until its last stage holds a result too. No clearing pass after reset.
// ----------------------------------------------------------------------------
module cubemap_texel_sampler_core
   import cts_pkg::*;
#(
   parameter int MAX_SIZE_LOG2    = 6,
   parameter int WEIGHT_FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dir_x, dir_y, dir_z, level, face, tex_x, tex_y,
   // wr_red, wr_green, wr_blue, wr_alpha, zero pad
   input  logic [135:0] req_tdata,
   // action
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // red, green, blue, alpha, face_used, zero pad
   output logic [71:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_data
);

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int QUO_W  = MAX_SIZE_LOG2 + F + 1;
   localparam int CW     = (MAX_SIZE_LOG2 > 0) ? MAX_SIZE_LOG2 : 1;
   localparam int IX_W   = MAX_SIZE_LOG2 + 1;
   localparam int NUM_W  = DIR_W + 1;
   localparam int SIDE_W = $bits(side_type);
   localparam int DEPTH  = lvl_base(MAX_SIZE_LOG2 + 1, MAX_SIZE_LOG2);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [F:0] ONE = (F + 1)'(1) << F;

   // ---------------------------------------------------------------- control
   logic adv;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_eff;

   // size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   always_comb begin
      if (int'(size_ff) > MAX_SIZE_LOG2) size_eff = SIZE_W'(MAX_SIZE_LOG2);
      else size_eff = size_ff;
   end

   // ---------------------------------------------------------------- input stage
   logic                 p0_vld_ff;
   logic                 p0_write_ff;
   logic                 p0_bilin_ff;
   logic [DIR_W-1:0]     p0_dx_ff;
   logic [DIR_W-1:0]     p0_dy_ff;
   logic [DIR_W-1:0]     p0_dz_ff;
   logic [LEVEL_W-1:0]   p0_level_ff;
   logic [FACE_W-1:0]    p0_face_ff;
   logic [TEX_W-1:0]     p0_tx_ff;
   logic [TEX_W-1:0]     p0_ty_ff;
   logic [TEXEL_W-1:0]   p0_texel_ff;

   assign req_tready = adv;

   // drop unused actions at the door
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
      end else if (adv) begin
         p0_vld_ff <= req_tvalid && (req_tuser != ACT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_write_ff <= (req_tuser == ACT_WRITE);
         p0_bilin_ff <= (req_tuser == ACT_BILINEAR);
         p0_dx_ff    <= req_tdata[15:0];
         p0_dy_ff    <= req_tdata[31:16];
         p0_dz_ff    <= req_tdata[47:32];
         p0_level_ff <= req_tdata[50:48];
         p0_face_ff  <= req_tdata[53:51];
         p0_tx_ff    <= req_tdata[59:54];
         p0_ty_ff    <= req_tdata[65:60];
         p0_texel_ff <= req_tdata[129:66];
      end
   end

   // ---------------------------------------------------------------- face pick
   logic [NUM_W-1:0]   ax, ay, az, mag;
   logic [NUM_W:0]     sx, sy, sz, mm, nu_s, nv_s;
   logic               sel_x, sel_y, pos_x, pos_y, pos_z, dir_zero;
   logic [FACE_W-1:0]  face_pick;
   logic [NUM_W-1:0]   num_u, num_v, den;
   side_type           side_in;

   always_comb begin
      ax = p0_dx_ff[DIR_W-1] ? NUM_W'(0) - {1'b1, p0_dx_ff} : {1'b0, p0_dx_ff};
      ay = p0_dy_ff[DIR_W-1] ? NUM_W'(0) - {1'b1, p0_dy_ff} : {1'b0, p0_dy_ff};
      az = p0_dz_ff[DIR_W-1] ? NUM_W'(0) - {1'b1, p0_dz_ff} : {1'b0, p0_dz_ff};
      sx = {{2{p0_dx_ff[DIR_W-1]}}, p0_dx_ff};
      sy = {{2{p0_dy_ff[DIR_W-1]}}, p0_dy_ff};
      sz = {{2{p0_dz_ff[DIR_W-1]}}, p0_dz_ff};
      pos_x = !p0_dx_ff[DIR_W-1] && (p0_dx_ff != '0);
      pos_y = !p0_dy_ff[DIR_W-1] && (p0_dy_ff != '0);
      pos_z = !p0_dz_ff[DIR_W-1] && (p0_dz_ff != '0);
      dir_zero = (ax == '0) && (ay == '0) && (az == '0);
      sel_x = (ax >= ay) && (ax >= az);
      sel_y = !sel_x && (ay >= az);
      if (sel_x) begin
         mag       = ax;
         mm        = {1'b0, ax};
         face_pick = pos_x ? FACE_PX : FACE_NX;
         nu_s      = pos_x ? mm + sz : mm - sz;
         nv_s      = mm - sy;
      end else if (sel_y) begin
         mag       = ay;
         mm        = {1'b0, ay};
         face_pick = pos_y ? FACE_PY : FACE_NY;
         nu_s      = mm - sx;
         nv_s      = pos_y ? mm + sz : mm - sz;
      end else begin
         mag       = az;
         mm        = {1'b0, az};
         face_pick = pos_z ? FACE_PZ : FACE_NZ;
         nu_s      = pos_z ? mm - sx : mm + sx;
         nv_s      = mm - sy;
      end
      num_u = nu_s[NUM_W-1:0];
      num_v = nv_s[NUM_W-1:0];
      den   = {mag[NUM_W-2:0], 1'b0};

      side_in.is_write = p0_write_ff;
      side_in.is_bilin = p0_bilin_ff;
      side_in.level    = p0_level_ff;
      side_in.tex_x    = p0_tx_ff;
      side_in.tex_y    = p0_ty_ff;
      side_in.texel    = p0_texel_ff;
      if (p0_write_ff) begin
         side_in.face   = p0_face_ff;
         side_in.status = ST_OK;
      end else if (dir_zero) begin
         side_in.face   = FACE_PX;
         side_in.status = ST_ZERO;
      end else if (p0_level_ff > size_eff) begin
         side_in.face   = face_pick;
         side_in.status = ST_LEVEL;
      end else begin
         side_in.face   = face_pick;
         side_in.status = ST_OK;
      end
   end

   // ---------------------------------------------------------------- divider
   logic              dv_vld;
   logic [QUO_W-1:0]  quo_u, quo_v;
   logic [SIDE_W-1:0] dv_side_raw;
   side_type          dv_side;

   cts_div #(
      .NUM_W  (NUM_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (p0_vld_ff),
      .num_u    (num_u),
      .num_v    (num_v),
      .den      (den),
      .in_side  (side_in),
      .out_vld  (dv_vld),
      .quo_u    (quo_u),
      .quo_v    (quo_v),
      .out_side (dv_side_raw)
   );

   assign dv_side = side_type'(dv_side_raw);

   // ---------------------------------------------------------------- address stage
   logic [ADDR_W-1:0]  off_tab [8];
   logic [LEVEL_W-1:0] el;
   logic [SHIFT_W-1:0] sh;
   logic [QUO_W-1:0]   pos_u, pos_v;
   logic [IX_W-1:0]    raw_x, raw_y, em1;
   logic               clamp_x, clamp_y, sample_ok, wr_ok;
   logic [CW-1:0]      ix0, ix1, iy0, iy1, wtx, wty;
   logic [F:0]         wx, wy;
   logic [ADDR_W-1:0]  rd_addr [4];
   logic [ADDR_W-1:0]  wr_addr;
   logic [CW-1:0]      ry, rx;
   logic [3:0]         bank_we;
   logic [1:0]         wr_bank;
   logic [TEXEL_W-1:0] bank_rd [4];

   for (genvar l = 0; l < 8; l++) begin : g_off
      assign off_tab[l] = ADDR_W'(lvl_base(l, MAX_SIZE_LOG2));
   end

   function automatic logic [ADDR_W-1:0] bank_addr(input logic [LEVEL_W-1:0] lv,
                                                   input logic [FACE_W-1:0]  fc,
                                                   input logic [CW-1:0]      yy,
                                                   input logic [CW-1:0]      xx);
      int hsh;
      hsh = MAX_SIZE_LOG2 - int'(lv) - 1;
      if (hsh < 0) hsh = 0;
      return off_tab[lv] + (ADDR_W'(fc) << (2 * hsh))
           + (ADDR_W'(yy >> 1) << hsh) + ADDR_W'(xx >> 1);
   endfunction

   // texel positions, clamped indexes and weights
   always_comb begin
      el      = size_eff - dv_side.level;
      sh      = SHIFT_W'(MAX_SIZE_LOG2) - SHIFT_W'(el);
      pos_u   = quo_u >> sh;
      pos_v   = quo_v >> sh;
      raw_x   = pos_u[QUO_W-1:F];
      raw_y   = pos_v[QUO_W-1:F];
      em1     = (IX_W'(1) << el) - IX_W'(1);
      clamp_x = raw_x > em1;
      clamp_y = raw_y > em1;
      ix0     = clamp_x ? em1[CW-1:0] : raw_x[CW-1:0];
      iy0     = clamp_y ? em1[CW-1:0] : raw_y[CW-1:0];
      ix1     = (IX_W'(ix0) == em1) ? ix0 : ix0 + CW'(1);
      iy1     = (IX_W'(iy0) == em1) ? iy0 : iy0 + CW'(1);
      sample_ok = dv_vld && !dv_side.is_write && (dv_side.status == ST_OK);
      if (sample_ok && dv_side.is_bilin) begin
         wx = clamp_x ? ONE : {1'b0, pos_u[F-1:0]};
         wy = clamp_y ? ONE : {1'b0, pos_v[F-1:0]};
      end else begin
         wx = '0;
         wy = '0;
      end

      // each bank takes whichever neighbor has its parity
      for (int b = 0; b < 4; b++) begin
         ry = (iy0[0] == b[1]) ? iy0 : iy1;
         rx = (ix0[0] == b[0]) ? ix0 : ix1;
         rd_addr[b] = bank_addr(dv_side.level, dv_side.face, ry, rx);
      end

      // store path
      wtx     = CW'(dv_side.tex_x);
      wty     = CW'(dv_side.tex_y);
      wr_ok   = dv_vld && dv_side.is_write && (dv_side.level <= size_eff)
             && (dv_side.face <= FACE_NZ)
             && ((dv_side.tex_x >> el) == '0) && ((dv_side.tex_y >> el) == '0);
      wr_addr = bank_addr(dv_side.level, dv_side.face, wty, wtx);
      wr_bank = {wty[0], wtx[0]};
      for (int b = 0; b < 4; b++) begin
         bank_we[b] = adv && wr_ok && (wr_bank == 2'(b));
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      cts_bank #(
         .ADDR_W (ADDR_W),
         .DEPTH  (DEPTH),
         .DATA_W (TEXEL_W)
      ) u_bank (
         .clock   (clock),
         .rd_en   (adv),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_rd[b]),
         .wr_en   (bank_we[b]),
         .wr_addr (wr_addr),
         .wr_data (dv_side.texel)
      );
   end

   // ---------------------------------------------------------------- memory stage
   logic               m1_vld_ff, b1_vld_ff, b2_vld_ff;
   logic [STAT_W-1:0]  m1_status_ff, b1_status_ff, b2_status_ff;
   logic [FACE_W-1:0]  m1_face_ff, b1_face_ff, b2_face_ff;
   logic [F:0]         m1_wx_ff, m1_wy_ff;
   logic               m1_px0_ff, m1_px1_ff, m1_py0_ff, m1_py1_ff;
   logic [3:0][TEXEL_W-1:0] tex;
   logic [3:0][CHAN_W-1:0]  color;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= dv_vld && !dv_side.is_write;
         b1_vld_ff <= m1_vld_ff;
         b2_vld_ff <= b1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_status_ff <= dv_side.status;
         m1_face_ff   <= dv_side.face;
         m1_wx_ff     <= wx;
         m1_wy_ff     <= wy;
         m1_px0_ff    <= ix0[0];
         m1_px1_ff    <= ix1[0];
         m1_py0_ff    <= iy0[0];
         m1_py1_ff    <= iy1[0];
         b1_status_ff <= m1_status_ff;
         b1_face_ff   <= m1_face_ff;
         b2_status_ff <= b1_status_ff;
         b2_face_ff   <= b1_face_ff;
      end
   end

   // route bank outputs to footprint corners
   always_comb begin
      tex[0] = bank_rd[{m1_py0_ff, m1_px0_ff}];
      tex[1] = bank_rd[{m1_py0_ff, m1_px1_ff}];
      tex[2] = bank_rd[{m1_py1_ff, m1_px0_ff}];
      tex[3] = bank_rd[{m1_py1_ff, m1_px1_ff}];
   end

   cts_blend #(
      .FRAC (F)
   ) u_blend (
      .clock (clock),
      .en    (adv),
      .tex   (tex),
      .wx    (m1_wx_ff),
      .wy    (m1_wy_ff),
      .color (color)
   );

   // ---------------------------------------------------------------- output register
   logic                    rsp_vld_ff;
   logic [3:0][CHAN_W-1:0]  rsp_color_ff;
   logic [FACE_W-1:0]       rsp_face_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic                    rsp_load;

   assign rsp_load = !rsp_vld_ff || rsp_tready;
   assign adv      = !b2_vld_ff || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= b2_vld_ff;
      end
   end

   // zero the colors of flagged samples
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff  <= (b2_status_ff == ST_OK) ? color : '0;
         rsp_face_ff   <= b2_face_ff;
         rsp_status_ff <= b2_status_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_face_ff, rsp_color_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_flag_no_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[63:0] == '0))
      else $error("flagged result carries color");

   a_zero_face: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_ZERO)) |-> (rsp_tdata[66:64] == FACE_PX))
      else $error("zero direction result carries a face");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one bank written");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (b2_vld_ff && rsp_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("pipeline advanced into a stalled output");
`endif

endmodule

// ===== tb/tb_cubemap_texel_sampler_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubemap_texel_sampler_core: self-checking bench for the cube-map sampler
// Fills every texel the samples can reach, then streams directed and random
// write and sample transactions under several size settings. A local model
// of the face pick, coordinate math and blend predicts every result; the
// monitor compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_cubemap_texel_sampler_core;
   import cts_pkg::*;

   localparam int MAX_LOG2 = 6;
   localparam int FRAC     = 8;
   localparam int LAT      = MAX_LOG2 + FRAC + 6;
   // filled square per level; other than the far-corner samples, samples only use the three smallest levels
   // of the sizes 0, 3 and 6
   localparam int FILL_SPAN [7] = '{1, 4, 2, 1, 4, 2, 1};

   typedef struct {
      logic [ACT_W-1:0]          act;
      logic signed [DIR_W-1:0]   dx, dy, dz;
      logic [LEVEL_W-1:0]        lvl;
      logic [FACE_W-1:0]         face;
      logic [TEX_W-1:0]          tx, ty;
      logic [CHAN_W-1:0]         r, g, b, a;
   } tex_req_type;

   typedef struct {
      logic [CHAN_W-1:0] r, g, b, a;
      logic [FACE_W-1:0] face;
      logic [STAT_W-1:0] status;
   } sample_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_data = '0;

   tex_req_type        pending_q[$];
   sample_type         sample_q[$];
   logic [TEXEL_W-1:0] texels[longint];
   logic [SIZE_W-1:0]  size_cfg = SIZE_RESET;

   int  errors = 0;
   int  accepted_cnt = 0;
   int  quiet_from = 32'h7fffffff;
   int  in_gap = 0;
   int  out_hold = 0;
   bit  long_done = 0;
   int  n_samples = 0;
   int  n_writes = 0;
   int  n_settings = 0;

   cubemap_texel_sampler_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // store address laid out for the deepest chain
   function automatic longint texel_addr(int lvl, int face, longint ty, longint tx);
      longint off;
      int sh;
      off = 0;
      sh = MAX_LOG2 - lvl;
      for (int k = 0; k < lvl; k++) off += longint'(6) << (2 * (MAX_LOG2 - k));
      return off + (longint'(face) << (2 * sh)) + (ty << sh) + tx;
   endfunction

   function automatic longint face_pos(longint n, longint m, int el);
      return (n << (el + FRAC)) / (2 * m);
   endfunction

   // apply one accepted transaction to the local store and queue its result
   task automatic predict_texel(input tex_req_type it);
      int          eff, lvl, el, fc;
      longint      x, y, z, ax, ay, az, m, nu, nv, span, px, py;
      longint      ix0, iy0, ix1, iy1, wx, wy, one, sum;
      logic [63:0] t[4];
      sample_type  res;
      eff = (size_cfg > MAX_LOG2) ? MAX_LOG2 : int'(size_cfg);
      lvl = int'(it.lvl);
      res = '{default: '0};
      if (it.act == ACT_WRITE) begin
         n_writes++;
         if (lvl > eff || it.face > FACE_NZ) return;
         span = longint'(1) << (eff - lvl);
         if (it.tx >= span || it.ty >= span) return;
         texels[texel_addr(lvl, it.face, it.ty, it.tx)] = {it.a, it.b, it.g, it.r};
         return;
      end
      if (it.act == ACT_NONE) return;
      n_samples++;
      x = it.dx; y = it.dy; z = it.dz;
      if (x == 0 && y == 0 && z == 0) begin
         res.status = ST_ZERO;
         sample_q.push_back(res);
         return;
      end
      ax = x < 0 ? -x : x; ay = y < 0 ? -y : y; az = z < 0 ? -z : z;
      if (ax >= ay && ax >= az) begin
         m = ax; fc = x > 0 ? int'(FACE_PX) : int'(FACE_NX);
         nu = x > 0 ? m + z : m - z; nv = m - y;
      end else if (ay >= az) begin
         m = ay; fc = y > 0 ? int'(FACE_PY) : int'(FACE_NY);
         nu = m - x; nv = y > 0 ? m + z : m - z;
      end else begin
         m = az; fc = z > 0 ? int'(FACE_PZ) : int'(FACE_NZ);
         nu = z > 0 ? m - x : m + x; nv = m - y;
      end
      res.face = FACE_W'(fc);
      if (lvl > eff) begin
         res.status = ST_LEVEL;
         sample_q.push_back(res);
         return;
      end
      el = eff - lvl;
      span = longint'(1) << el;
      px = face_pos(nu, m, el);
      py = face_pos(nv, m, el);
      ix0 = px >> FRAC; iy0 = py >> FRAC;
      if (ix0 > span - 1) ix0 = span - 1;
      if (iy0 > span - 1) iy0 = span - 1;
      if (it.act == ACT_NEAREST) begin
         t[0] = texels[texel_addr(lvl, fc, iy0, ix0)];
         {res.a, res.b, res.g, res.r} = t[0];
         sample_q.push_back(res);
         return;
      end
      ix1 = (ix0 + 1 > span - 1) ? span - 1 : ix0 + 1;
      iy1 = (iy0 + 1 > span - 1) ? span - 1 : iy0 + 1;
      one = longint'(1) << FRAC;
      wx = px - (ix0 << FRAC); wy = py - (iy0 << FRAC);
      if (wx > one) wx = one;
      if (wy > one) wy = one;
      t[0] = texels[texel_addr(lvl, fc, iy0, ix0)];
      t[1] = texels[texel_addr(lvl, fc, iy0, ix1)];
      t[2] = texels[texel_addr(lvl, fc, iy1, ix0)];
      t[3] = texels[texel_addr(lvl, fc, iy1, ix1)];
      for (int j = 0; j < 4; j++) begin
         sum = longint'(t[0][16*j +: 16]) * (one - wx) * (one - wy)
             + longint'(t[1][16*j +: 16]) * wx * (one - wy)
             + longint'(t[2][16*j +: 16]) * (one - wx) * wy
             + longint'(t[3][16*j +: 16]) * wx * wy;
         sum = (sum + (longint'(1) << (2 * FRAC - 1))) >> (2 * FRAC);
         if (sum > 65535) sum = 65535;
         case (j)
            0: res.r = sum[15:0];
            1: res.g = sum[15:0];
            2: res.b = sum[15:0];
            default: res.a = sum[15:0];
         endcase
      end
      sample_q.push_back(res);
   endtask

   function automatic logic [135:0] pack_req(tex_req_type it);
      return {6'b0, it.a, it.b, it.g, it.r, it.ty, it.tx, it.face, it.lvl,
              it.dz, it.dy, it.dx};
   endfunction

   // request driver: hold a pending transaction until accepted, idle at random
   always @(posedge clock) begin
      logic sent;
      sent = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (sent) begin
            predict_texel(pending_q[0]);
            void'(pending_q.pop_front());
            accepted_cnt++;
         end
         if (req_tvalid && !sent) begin
            // hold the offered transaction
         end else if (in_gap > 0) begin
            in_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            if (accepted_cnt < quiet_from && $urandom_range(0, 15) == 0) begin
               in_gap = $urandom_range(1, 11) - 1;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= pack_req(pending_q[0]);
               req_tuser  <= pending_q[0].act;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result ready: random stalls, one long hold-off to back up the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (out_hold > 0) begin
         out_hold--;
         rsp_tready <= 1'b0;
      end else if (!long_done && accepted_cnt >= 300) begin
         long_done = 1;
         out_hold = 400;
         rsp_tready <= 1'b0;
      end else if (accepted_cnt < quiet_from && $urandom_range(0, 9) == 0) begin
         out_hold = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      sample_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {got.a, got.b, got.g, got.r} = rsp_tdata[63:0];
         got.face   = rsp_tdata[66:64];
         got.status = rsp_tuser;
         if (sample_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual face %0d status %0d", $time,
                     got.face, got.status);
         end else begin
            want = sample_q.pop_front();
            if (got.r !== want.r) begin
               errors++;
               $display("%0t: red expected %h actual %h", $time, want.r, got.r);
            end
            if (got.g !== want.g) begin
               errors++;
               $display("%0t: green expected %h actual %h", $time, want.g, got.g);
            end
            if (got.b !== want.b) begin
               errors++;
               $display("%0t: blue expected %h actual %h", $time, want.b, got.b);
            end
            if (got.a !== want.a) begin
               errors++;
               $display("%0t: alpha expected %h actual %h", $time, want.a, got.a);
            end
            if (got.face !== want.face) begin
               errors++;
               $display("%0t: face expected %0d actual %0d", $time, want.face, got.face);
            end
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
            end
         end
      end
   end

   function automatic tex_req_type sample_req(logic [1:0] act, int x, int y, int z,
                                              int lvl);
      tex_req_type it;
      it.act = act; it.dx = DIR_W'(x); it.dy = DIR_W'(y); it.dz = DIR_W'(z);
      it.lvl = LEVEL_W'(lvl);
      it.face = FACE_W'($urandom); it.tx = TEX_W'($urandom); it.ty = TEX_W'($urandom);
      it.r = CHAN_W'($urandom); it.g = CHAN_W'($urandom);
      it.b = CHAN_W'($urandom); it.a = CHAN_W'($urandom);
      return it;
   endfunction

   function automatic tex_req_type write_req(int lvl, int face, int tx, int ty);
      tex_req_type it;
      it = sample_req(ACT_WRITE, int'($urandom), int'($urandom), int'($urandom), lvl);
      it.face = FACE_W'(face); it.tx = TEX_W'(tx); it.ty = TEX_W'(ty);
      return it;
   endfunction

   function automatic int rand_comp();
      case ($urandom_range(0, 3))
         0: return $signed(16'($urandom));
         1: return int'($urandom_range(0, 6)) - 3;
         2: case ($urandom_range(0, 2))
               0: return -32768;
               1: return 32767;
               default: return 0;
            endcase
         default: return int'($urandom_range(0, 511)) - 256;
      endcase
   endfunction

   // mostly valid samples and writes at the current size, some noise
   task automatic queue_random(int n);
      tex_req_type it;
      int eff, lo, x, y, z, span;
      eff = (size_cfg > MAX_LOG2) ? MAX_LOG2 : int'(size_cfg);
      lo = (eff > 2) ? eff - 2 : 0;
      for (int i = 0; i < n; i++) begin
         x = rand_comp(); y = rand_comp(); z = rand_comp();
         if ($urandom_range(0, 5) == 0) y = $urandom_range(0, 1) ? x : -x;
         if ($urandom_range(0, 5) == 0) z = $urandom_range(0, 1) ? y : -y;
         case ($urandom_range(0, 9))
            0, 1: begin
               it = write_req($urandom_range(0, eff), $urandom_range(0, 5), 0, 0);
               span = 1 << (eff - int'(it.lvl));
               it.tx = TEX_W'($urandom_range(0, span - 1));
               it.ty = TEX_W'($urandom_range(0, span - 1));
            end
            2: begin
               it = write_req($urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 63), $urandom_range(0, 63));
               if ($urandom_range(0, 3) == 0) it.act = ACT_NONE;
            end
            default: begin
               it = sample_req($urandom_range(0, 1) ? ACT_NEAREST : ACT_BILINEAR,
                               x, y, z, $urandom_range(0, 7) == 0 ?
                               $urandom_range(eff + 1, 7) : $urandom_range(lo, eff));
            end
         endcase
         pending_q.push_back(it);
      end
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || req_tvalid || sample_q.size() > 0)
         @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   task automatic write_size(logic [2:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      size_cfg = v;
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_size(3'd6);

      // fill every texel a sample can reach so none reads an unwritten entry
      for (int l = 0; l <= MAX_LOG2; l++)
         for (int f = 0; f < 6; f++)
            for (int ty = 0; ty < FILL_SPAN[l]; ty++)
               for (int tx = 0; tx < FILL_SPAN[l]; tx++)
                  pending_q.push_back(write_req(l, f, tx, ty));

      // directed: zero, level past chain, ties, axis extremes, dropped writes
      pending_q.push_back(sample_req(ACT_NEAREST, 0, 0, 0, 0));
      pending_q.push_back(sample_req(ACT_BILINEAR, 0, 0, 0, 7));
      pending_q.push_back(sample_req(ACT_NEAREST, 5, -3, 1, 7));
      pending_q.push_back(sample_req(ACT_BILINEAR, 100, 100, 100, 4));
      pending_q.push_back(sample_req(ACT_BILINEAR, -7, 7, 2, 5));
      pending_q.push_back(sample_req(ACT_NEAREST, 1, -9, 9, 6));
      pending_q.push_back(sample_req(ACT_NEAREST, 32767, 32767, -32768, 4));
      pending_q.push_back(sample_req(ACT_BILINEAR, -32768, 32767, 32767, 5));
      pending_q.push_back(sample_req(ACT_BILINEAR, 3, -32768, -32768, 6));
      pending_q.push_back(sample_req(ACT_NEAREST, 1, 2, -32768, 4));
      pending_q.push_back(sample_req(ACT_BILINEAR, 32767, 0, 0, 5));
      pending_q.push_back(sample_req(ACT_NEAREST, 0, 32767, 0, 6));
      pending_q.push_back(sample_req(ACT_BILINEAR, 0, 0, -1, 6));
      pending_q.push_back(write_req(0, 6, 0, 0));
      pending_q.push_back(write_req(0, 7, 63, 63));
      pending_q.push_back(write_req(7, 0, 0, 0));
      pending_q[$].act = ACT_NONE;
      // far corner of the largest face, read back by clamped samples
      pending_q.push_back(write_req(0, 0, 63, 63));
      pending_q.push_back(sample_req(ACT_NEAREST, 1, -1, 1, 0));
      pending_q.push_back(sample_req(ACT_BILINEAR, 1, -1, 1, 0));
      queue_random(100);
      wait_idle();

      // smallest chain, then mid, then above the maximum
      write_size(3'd0);
      pending_q.push_back(write_req(0, 2, 1, 0));
      pending_q.push_back(sample_req(ACT_BILINEAR, -1, 9, 1, 0));
      queue_random(60);
      wait_idle();
      write_size(3'd3);
      queue_random(60);
      wait_idle();
      write_size(3'd7);
      queue_random(60);
      wait_idle();

      // back to full size; no idling over the last stretch
      write_size(3'd6);
      quiet_from = accepted_cnt + 100;
      queue_random(190);
      wait_idle();

      $display("Covered %0d samples and %0d writes over %0d size settings",
               n_samples, n_writes, n_settings);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout waiting for the run to drain");
      $display("Mismatches found");
      $finish;
   end

endmodule
